>>> sv/viatr_pkg.sv
// ----------------------------------------------------------------------------
// viatr_pkg: shared types and constants for the interface adapter timer regs
// Action codes, register numbers, masks and the timer status record.
// ----------------------------------------------------------------------------
`default_nettype none

package viatr_pkg;

    typedef enum logic [1:0] {
        ACT_READ    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_ADVANCE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Register map
    localparam logic [3:0] REG_ORB   = 4'h0;
    localparam logic [3:0] REG_ORA   = 4'h1;
    localparam logic [3:0] REG_DDRB  = 4'h2;
    localparam logic [3:0] REG_DDRA  = 4'h3;
    localparam logic [3:0] REG_T1CL  = 4'h4;
    localparam logic [3:0] REG_T1CH  = 4'h5;
    localparam logic [3:0] REG_T1LL  = 4'h6;
    localparam logic [3:0] REG_T1LH  = 4'h7;
    localparam logic [3:0] REG_T2CL  = 4'h8;
    localparam logic [3:0] REG_T2CH  = 4'h9;
    localparam logic [3:0] REG_ACR   = 4'hB;
    localparam logic [3:0] REG_IFR   = 4'hD;
    localparam logic [3:0] REG_IER   = 4'hE;

    localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
    localparam logic [7:0] MASK_LOW6     = 8'h3F;
    localparam logic [7:0] MASK_LOW7     = 8'h7F;
    localparam logic [7:0] BIT_T1        = 8'h40;
    localparam logic [7:0] BIT_ANY       = 8'h80;

    typedef struct packed {
        logic raise;   // timer 1 expired in continuous mode with its interrupt enabled
        logic oneshot; // one-shot expiry: drop enable bits 7:6
    } timer_status_t;

endpackage

`default_nettype wire

>>> sv/viatr_timer.sv
// ----------------------------------------------------------------------------
// viatr_timer: time advance for timer 1 and timer 2
// Computes both counters after a run of elapsed cycles and timer 1 expiry.
// ----------------------------------------------------------------------------
`default_nettype none

module viatr_timer (
    input  wire logic [15:0]            t1_count,
    input  wire logic [15:0]            t1_reload,
    input  wire logic [15:0]            t2_count,
    input  wire logic [7:0]             aux_control,
    input  wire logic [7:0]             irq_enables,
    input  wire logic [15:0]            cycles,
    output logic [15:0]                 t1_count_next,
    output logic [15:0]                 t2_count_next,
    output viatr_pkg::timer_status_t    status
);

    logic [15:0] t1_dec;
    logic        hit;
    logic        continuous;

    assign hit        = (t1_count <= cycles);
    assign continuous = |(aux_control & viatr_pkg::BIT_T1);
    assign t1_dec     = t1_count - cycles;

    // Reload on expiry in continuous mode, wrap modulo 2^16
    assign t1_count_next = (hit && continuous) ? (t1_dec + t1_reload) : t1_dec;
    assign t2_count_next = t2_count - cycles;

    assign status.raise   = hit && continuous && |(irq_enables & viatr_pkg::BIT_T1);
    assign status.oneshot = hit && !continuous;

endmodule

`default_nettype wire

>>> sv/via_interface_adapter_timer_regs.sv
// ----------------------------------------------------------------------------
// via_interface_adapter_timer_regs: register file and timers of a VIA-style
// interface adapter
// Port, direction, timer, aux control and interrupt registers behind a bus.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is a bus read, a bus write, or an advance
//   of time by s_cycle_count cycles (s_action). Every request yields exactly
//   one response on the m_ channel: m_read_data carries the register value
//   for a read and zero otherwise; m_irq_raised flags an advance in which
//   timer 1 expired in continuous mode with its interrupt enabled.
//   The register state updates and the response is captured in the output
//   register at the edge that accepts the request, and m_valid rises in the
//   next cycle. Throughput is one request per cycle while the receiver
//   takes each response; the single combinational pass (timer 1 compare,
//   subtract and reload add) sets that figure.
//   s_ready is high whenever the output register is empty or being drained
//   in the same cycle, so a stalled receiver holds the response and blocks
//   new requests only until it takes it.
//   Synchronous active-low reset clears every state register to zero and
//   empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module via_interface_adapter_timer_regs (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [3:0]  s_reg_index,
    input  wire logic [7:0]  s_write_byte,
    input  wire logic [15:0] s_cycle_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data,
    output logic             m_irq_raised
);

    // Adapter state
    logic [7:0]  port_b_out_reg, port_b_out_next;
    logic [7:0]  port_a_out_reg, port_a_out_next;
    logic [7:0]  port_b_dir_reg, port_b_dir_next;
    logic [7:0]  port_a_dir_reg, port_a_dir_next;
    logic [15:0] t1_count_reg, t1_count_next;
    logic [15:0] t1_reload_reg, t1_reload_next;
    logic [15:0] t2_count_reg, t2_count_next;
    logic [7:0]  aux_control_reg, aux_control_next;
    logic [7:0]  irq_flags_reg, irq_flags_next;
    logic [7:0]  irq_enables_reg, irq_enables_next;

    // Response register
    logic        m_valid_reg;
    logic [7:0]  m_read_data_reg, m_read_data_next;
    logic        m_irq_raised_reg, m_irq_raised_next;

    logic        accept;
    logic [7:0]  read_value;
    logic [6:0]  flags_low;
    logic [15:0] adv_t1_count;
    logic [15:0] adv_t2_count;
    viatr_pkg::timer_status_t adv_status;
    viatr_pkg::action_t       action;

    assign action  = viatr_pkg::action_t'(s_action);
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign m_valid      = m_valid_reg;
    assign m_read_data  = m_read_data_reg;
    assign m_irq_raised = m_irq_raised_reg;

    viatr_timer u_timer (
        .t1_count      (t1_count_reg),
        .t1_reload     (t1_reload_reg),
        .t2_count      (t2_count_reg),
        .aux_control   (aux_control_reg),
        .irq_enables   (irq_enables_reg),
        .cycles        (s_cycle_count),
        .t1_count_next (adv_t1_count),
        .t2_count_next (adv_t2_count),
        .status        (adv_status)
    );

    // Read decode; interrupt flag bit 7 summarizes bits 6:0
    assign flags_low = irq_flags_reg[6:0];

    always_comb begin
        unique case (s_reg_index)
            viatr_pkg::REG_ORB:  read_value = viatr_pkg::BYTE_ALL_ONES;
            viatr_pkg::REG_ORA:  read_value = port_a_out_reg & port_a_dir_reg;
            viatr_pkg::REG_DDRB: read_value = port_b_dir_reg;
            viatr_pkg::REG_DDRA: read_value = port_a_dir_reg;
            viatr_pkg::REG_T1CL: read_value = t1_count_reg[7:0];
            viatr_pkg::REG_T1CH: read_value = t1_count_reg[15:8];
            viatr_pkg::REG_T1LL: read_value = t1_reload_reg[7:0];
            viatr_pkg::REG_T1LH: read_value = t1_reload_reg[15:8];
            viatr_pkg::REG_T2CL: read_value = t2_count_reg[7:0];
            viatr_pkg::REG_T2CH: read_value = t2_count_reg[15:8];
            viatr_pkg::REG_ACR:  read_value = aux_control_reg;
            viatr_pkg::REG_IFR:  read_value = {|flags_low, flags_low};
            viatr_pkg::REG_IER:  read_value = irq_enables_reg | viatr_pkg::BIT_ANY;
            default:             read_value = 8'h00;
        endcase
    end

    // Next state and response for the request on the input channel
    always_comb begin
        port_b_out_next   = port_b_out_reg;
        port_a_out_next   = port_a_out_reg;
        port_b_dir_next   = port_b_dir_reg;
        port_a_dir_next   = port_a_dir_reg;
        t1_count_next     = t1_count_reg;
        t1_reload_next    = t1_reload_reg;
        t2_count_next     = t2_count_reg;
        aux_control_next  = aux_control_reg;
        irq_flags_next    = irq_flags_reg;
        irq_enables_next  = irq_enables_reg;
        m_read_data_next  = 8'h00;
        m_irq_raised_next = 1'b0;

        unique case (action)
            viatr_pkg::ACT_READ: begin
                m_read_data_next = read_value;
            end
            viatr_pkg::ACT_WRITE: begin
                unique case (s_reg_index)
                    viatr_pkg::REG_ORB:  port_b_out_next = s_write_byte;
                    viatr_pkg::REG_ORA:  port_a_out_next = s_write_byte;
                    viatr_pkg::REG_DDRB: port_b_dir_next = s_write_byte;
                    viatr_pkg::REG_DDRA: port_a_dir_next = s_write_byte;
                    viatr_pkg::REG_T1CL, viatr_pkg::REG_T1LL: begin
                        t1_reload_next = {t1_reload_reg[15:8], s_write_byte};
                    end
                    viatr_pkg::REG_T1CH: begin
                        // Load latch high byte and restart timer 1
                        t1_reload_next = {s_write_byte, t1_reload_reg[7:0]};
                        t1_count_next  = {s_write_byte, t1_reload_reg[7:0]};
                        irq_flags_next = irq_flags_reg & viatr_pkg::MASK_LOW6;
                    end
                    viatr_pkg::REG_T1LH: begin
                        t1_reload_next = {s_write_byte, t1_reload_reg[7:0]};
                        irq_flags_next = irq_flags_reg & viatr_pkg::MASK_LOW6;
                    end
                    viatr_pkg::REG_ACR:  aux_control_next = s_write_byte;
                    viatr_pkg::REG_IFR:  irq_flags_next = irq_flags_reg & ~s_write_byte;
                    viatr_pkg::REG_IER: begin
                        // Bit 7 selects set or clear of the named enables
                        if (s_write_byte[7]) begin
                            irq_enables_next = irq_enables_reg | s_write_byte;
                        end else begin
                            irq_enables_next = irq_enables_reg & ~s_write_byte;
                        end
                    end
                    default: ;
                endcase
            end
            viatr_pkg::ACT_ADVANCE: begin
                t1_count_next = adv_t1_count;
                t2_count_next = adv_t2_count;
                if (adv_status.raise) begin
                    irq_flags_next    = irq_flags_reg | viatr_pkg::BIT_ANY
                                        | viatr_pkg::BIT_T1;
                    m_irq_raised_next = 1'b1;
                end
                if (adv_status.oneshot) begin
                    irq_enables_next = irq_enables_reg & viatr_pkg::MASK_LOW6;
                end
            end
            viatr_pkg::ACT_NONE: ;
            default: ;
        endcase
    end

    // State registers: advance only on an accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_b_out_reg  <= '0;
            port_a_out_reg  <= '0;
            port_b_dir_reg  <= '0;
            port_a_dir_reg  <= '0;
            t1_count_reg    <= '0;
            t1_reload_reg   <= '0;
            t2_count_reg    <= '0;
            aux_control_reg <= '0;
            irq_flags_reg   <= '0;
            irq_enables_reg <= '0;
        end else if (accept) begin
            port_b_out_reg  <= port_b_out_next;
            port_a_out_reg  <= port_a_out_next;
            port_b_dir_reg  <= port_b_dir_next;
            port_a_dir_reg  <= port_a_dir_next;
            t1_count_reg    <= t1_count_next;
            t1_reload_reg   <= t1_reload_next;
            t2_count_reg    <= t2_count_next;
            aux_control_reg <= aux_control_next;
            irq_flags_reg   <= irq_flags_next;
            irq_enables_reg <= irq_enables_next;
        end
    end

    // Response valid: set on accept, drop when taken without a new request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Response payload: hold while stalled
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_read_data_reg  <= m_read_data_next;
            m_irq_raised_reg <= m_irq_raised_next;
        end
    end

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the interface adapter register file
// Drives bus reads, bus writes and time advances through the s_ channel and
// checks every m_ channel response against a cycle-free behavioral predictor
// of the port, timer and interrupt registers. Directed cases come first,
// then random traffic under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------

module tb_top;

    // Registers with no function in the map
    localparam logic [3:0] REG_SPARE_A = 4'hA;
    localparam logic [3:0] REG_SPARE_C = 4'hC;
    localparam logic [3:0] REG_SPARE_F = 4'hF;

    // Abort after this many cycles with no handshake on either channel
    localparam int STALL_LIMIT = 5000;
    // Cycles to wait once the last response has been taken
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_raised;
    } response_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = viatr_pkg::ACT_READ;
    logic [3:0]  s_reg_index = '0;
    logic [7:0]  s_write_byte = '0;
    logic [15:0] s_cycle_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_read_data;
    logic        m_irq_raised;

    // Stall mix, in percent of cycles
    int send_idle_pct = 7;
    int recv_stall_pct = 63;

    int requests_sent = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // Responses predicted for accepted requests, oldest first
    response_t pending_responses[$];

    // Predicted register state, reset to zero
    logic [7:0]  port_b_q = '0;
    logic [7:0]  port_a_q = '0;
    logic [7:0]  dir_b_q = '0;
    logic [7:0]  dir_a_q = '0;
    logic [15:0] t1_cnt_q = '0;
    logic [15:0] t1_latch_q = '0;
    logic [15:0] t2_cnt_q = '0;
    logic [7:0]  acr_q = '0;
    logic [7:0]  ifr_q = '0;
    logic [7:0]  ier_q = '0;

    always #1 aclk = ~aclk;

    via_interface_adapter_timer_regs u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_reg_index   (s_reg_index),
        .s_write_byte  (s_write_byte),
        .s_cycle_count (s_cycle_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_irq_raised  (m_irq_raised)
    );

    // Apply one request to the predicted registers and return its response.
    function automatic response_t predict_response(input viatr_pkg::action_t act,
                                                   input logic [3:0] idx,
                                                   input logic [7:0] wbyte,
                                                   input logic [15:0] cycles);
        response_t  rsp;
        logic [7:0] low_flags;
        logic       expired;
        rsp = '0;
        case (act)
            viatr_pkg::ACT_READ: begin
                case (idx)
                    viatr_pkg::REG_ORB:  rsp.read_data = viatr_pkg::BYTE_ALL_ONES;
                    viatr_pkg::REG_ORA:  rsp.read_data = port_a_q & dir_a_q;
                    viatr_pkg::REG_DDRB: rsp.read_data = dir_b_q;
                    viatr_pkg::REG_DDRA: rsp.read_data = dir_a_q;
                    viatr_pkg::REG_T1CL: rsp.read_data = t1_cnt_q[7:0];
                    viatr_pkg::REG_T1CH: rsp.read_data = t1_cnt_q[15:8];
                    viatr_pkg::REG_T1LL: rsp.read_data = t1_latch_q[7:0];
                    viatr_pkg::REG_T1LH: rsp.read_data = t1_latch_q[15:8];
                    viatr_pkg::REG_T2CL: rsp.read_data = t2_cnt_q[7:0];
                    viatr_pkg::REG_T2CH: rsp.read_data = t2_cnt_q[15:8];
                    viatr_pkg::REG_ACR:  rsp.read_data = acr_q;
                    viatr_pkg::REG_IFR: begin
                        // Bit 7 summarizes the lower flags
                        low_flags = ifr_q & viatr_pkg::MASK_LOW7;
                        rsp.read_data = low_flags
                                        | ((low_flags != '0) ? viatr_pkg::BIT_ANY : 8'h00);
                    end
                    viatr_pkg::REG_IER:  rsp.read_data = ier_q | viatr_pkg::BIT_ANY;
                    default:             rsp.read_data = '0;
                endcase
            end
            viatr_pkg::ACT_WRITE: begin
                case (idx)
                    viatr_pkg::REG_ORB:  port_b_q = wbyte;
                    viatr_pkg::REG_ORA:  port_a_q = wbyte;
                    viatr_pkg::REG_DDRB: dir_b_q = wbyte;
                    viatr_pkg::REG_DDRA: dir_a_q = wbyte;
                    viatr_pkg::REG_T1CL, viatr_pkg::REG_T1LL: t1_latch_q[7:0] = wbyte;
                    viatr_pkg::REG_T1CH: begin
                        // Load the counter from the full latch and acknowledge timer 1
                        t1_latch_q[15:8] = wbyte;
                        t1_cnt_q = t1_latch_q;
                        ifr_q = ifr_q & viatr_pkg::MASK_LOW6;
                    end
                    viatr_pkg::REG_T1LH: begin
                        t1_latch_q[15:8] = wbyte;
                        ifr_q = ifr_q & viatr_pkg::MASK_LOW6;
                    end
                    viatr_pkg::REG_ACR:  acr_q = wbyte;
                    viatr_pkg::REG_IFR:  ifr_q = ifr_q & ~wbyte;
                    viatr_pkg::REG_IER: begin
                        // Bit 7 selects set or clear of the named bits
                        if (wbyte[7]) begin
                            ier_q = ier_q | wbyte;
                        end else begin
                            ier_q = ier_q & ~wbyte;
                        end
                    end
                    default: ;
                endcase
            end
            viatr_pkg::ACT_ADVANCE: begin
                expired = (t1_cnt_q <= cycles);
                t1_cnt_q = t1_cnt_q - cycles;
                t2_cnt_q = t2_cnt_q - cycles;
                if (expired) begin
                    if ((acr_q & viatr_pkg::BIT_T1) != '0) begin
                        // Continuous mode: reload and flag if enabled
                        t1_cnt_q = t1_cnt_q + t1_latch_q;
                        if ((ier_q & viatr_pkg::BIT_T1) != '0) begin
                            ifr_q = ifr_q | viatr_pkg::BIT_ANY | viatr_pkg::BIT_T1;
                            rsp.irq_raised = 1'b1;
                        end
                    end else begin
                        // One-shot expiry drops the top two enables
                        ier_q = ier_q & viatr_pkg::MASK_LOW6;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // Offer one request, hold it until accepted, then record its response.
    task automatic send_request(input viatr_pkg::action_t act, input logic [3:0] idx,
                                input logic [7:0] wbyte, input logic [15:0] cycles);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_reg_index   <= idx;
        s_write_byte  <= wbyte;
        s_cycle_count <= cycles;
        do @(posedge aclk); while (!s_ready);
        pending_responses.push_back(predict_response(act, idx, wbyte, cycles));
        requests_sent++;
    endtask

    // Unused fields carry random values so that every port bit toggles.
    task automatic read_reg(input logic [3:0] idx);
        send_request(viatr_pkg::ACT_READ, idx, 8'($urandom), 16'($urandom));
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [7:0] wbyte);
        send_request(viatr_pkg::ACT_WRITE, idx, wbyte, 16'($urandom));
    endtask

    task automatic advance_time(input logic [15:0] cycles);
        send_request(viatr_pkg::ACT_ADVANCE, 4'($urandom), 8'($urandom), cycles);
    endtask

    task automatic test_port_registers();
        read_reg(viatr_pkg::REG_ORB);
        write_reg(viatr_pkg::REG_DDRA, 8'hFF);
        write_reg(viatr_pkg::REG_ORA, 8'hA5);
        read_reg(viatr_pkg::REG_ORA);
        write_reg(viatr_pkg::REG_DDRB, 8'h81);
        read_reg(viatr_pkg::REG_DDRB);
    endtask

    task automatic test_interrupt_enables();
        write_reg(viatr_pkg::REG_IER, 8'hFF);
        write_reg(viatr_pkg::REG_IER, 8'h7F);
        read_reg(viatr_pkg::REG_IER);
    endtask

    task automatic test_timer1_continuous();
        write_reg(viatr_pkg::REG_ACR, viatr_pkg::BIT_T1);
        write_reg(viatr_pkg::REG_IER, viatr_pkg::BIT_ANY | viatr_pkg::BIT_T1);
        // Counter is still zero from reset: a zero-cycle advance expires it
        advance_time(16'h0000);
        read_reg(viatr_pkg::REG_IFR);
        write_reg(viatr_pkg::REG_IFR, 8'hFF);
        write_reg(viatr_pkg::REG_T1LH, 8'hFF);
        write_reg(viatr_pkg::REG_T1CH, 8'hFF);
        advance_time(16'hFFFF);
        read_reg(viatr_pkg::REG_T1CL);
    endtask

    task automatic test_timer1_oneshot();
        write_reg(viatr_pkg::REG_ACR, 8'h00);
        advance_time(16'hFFFF);
        read_reg(viatr_pkg::REG_IER);
    endtask

    task automatic test_unmapped_access();
        write_reg(viatr_pkg::REG_T2CH, 8'hFF);
        read_reg(REG_SPARE_A);
        read_reg(REG_SPARE_C);
        send_request(viatr_pkg::ACT_NONE, REG_SPARE_F, 8'hFF, 16'hFFFF);
    endtask

    // Random traffic: mostly reads, writes and advances, with timer
    // programming sequences mixed in so timer 1 expires often.
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        int stop_at;
        int pick;
        int n_adv;
        stop_at = requests_sent + count;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (requests_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 28) begin
                read_reg(4'($urandom));
            end else if (pick < 52) begin
                write_reg(4'($urandom), 8'($urandom));
            end else if (pick < 80) begin
                case ($urandom_range(4))
                    0:       advance_time(16'h0000);
                    1:       advance_time(16'($urandom));
                    2:       advance_time(16'hFFFF);
                    default: advance_time(16'($urandom_range(300)));
                endcase
            end else if (pick < 97) begin
                // Program timer 1, mostly with a short period, then let it run
                write_reg(viatr_pkg::REG_T1CL, 8'($urandom_range(60)));
                write_reg(viatr_pkg::REG_T1CH,
                          ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
                write_reg(viatr_pkg::REG_ACR, 8'($urandom)
                          | (($urandom_range(3) != 0) ? viatr_pkg::BIT_T1 : 8'h00));
                if ($urandom_range(1)) begin
                    write_reg(viatr_pkg::REG_IER,
                              viatr_pkg::BIT_ANY | viatr_pkg::BIT_T1 | 8'($urandom));
                end
                n_adv = $urandom_range(1, 5);
                repeat (n_adv) advance_time(16'($urandom_range(80)));
                read_reg(viatr_pkg::REG_IFR);
                if ($urandom_range(1)) begin
                    write_reg(viatr_pkg::REG_IFR, 8'($urandom));
                end
            end else begin
                send_request(viatr_pkg::ACT_NONE, 4'($urandom), 8'($urandom),
                             16'($urandom));
            end
        end
    endtask

    // Receiver: stall at random under the current mix.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each taken response with the oldest prediction.
    always @(posedge aclk) begin : check_responses
        response_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected response read_data=%h irq_raised=%b",
                         $time, m_read_data, m_irq_raised);
                mismatches++;
            end else begin
                want = pending_responses.pop_front();
                if (m_read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, m_read_data);
                    mismatches++;
                end
                if (m_irq_raised !== want.irq_raised) begin
                    $display("%0t: irq_raised expected %b actual %b",
                             $time, want.irq_raised, m_irq_raised);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part runs under the first stall mix
        test_port_registers();
        test_interrupt_enables();
        test_timer1_continuous();
        test_timer1_oneshot();
        test_unmapped_access();

        test_random_traffic(310, 7, 63);
        test_random_traffic(310, 63, 7);
        test_random_traffic(310, 0, 0);

        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain the outstanding responses, then let the pipe settle
        while (pending_responses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/viatr_pkg.sv
sv/viatr_timer.sv
sv/via_interface_adapter_timer_regs.sv
test/tb_top.sv
